### hdl/nft_pkg.sv
// Shared types, codes and sizes for the name forwarding table.
`default_nettype none
package nft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int KEY_BITS    = 32;

  // command codes
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NO_ROUTE  = 3'd5;
  localparam logic [2:0] ST_REMOVED   = 3'd6;

  // one stored route
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         hop;
    logic [47:0]         mac;
    logic [47:0]         expiry;
    logic [7:0]          port;
    logic [15:0]         quality;
    logic [31:0]         seq_num;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic restart;
    logic run;
    logic pass_b;
    logic commit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       last;
    logic [1:0] cmd;
  } stat_t;

endpackage
`default_nettype wire

### hdl/nft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module nft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/nft_datapath.sv
// Datapath: command registers, slot scan, selection trackers, route RAM.
`default_nettype none
module nft_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nft_pkg::ctl_t               ctl,
  output nft_pkg::stat_t                   stat,
  input  wire logic [1:0]                  command,
  input  wire logic [31:0]                 dest_key,
  input  wire logic [31:0]                 hop_name,
  input  wire logic [47:0]                 hop_mac,
  input  wire logic [31:0]                 ttl_ticks,
  input  wire logic [7:0]                  port_index,
  input  wire logic [15:0]                 link_quality,
  input  wire logic [47:0]                 now_ticks,
  output logic      [2:0]                  status,
  output logic      [31:0]                 route_hop,
  output logic      [47:0]                 route_mac,
  output logic      [7:0]                  route_port,
  output logic      [15:0]                 route_quality
);

  // captured command
  logic [1:0]                   cmd_q;
  logic [nft_pkg::KEY_BITS-1:0] key_q;
  logic [31:0]                  hop_q;
  logic [47:0]                  mac_q;
  logic [47:0]                  exp_q;
  logic [7:0]                   port_q;
  logic [15:0]                  qual_q;
  logic [47:0]                  now_q;

  // scan
  logic [nft_pkg::IDX_BITS-1:0]    cnt;
  logic                            rd_v;
  logic [nft_pkg::IDX_BITS-1:0]    rd_idx;
  nft_pkg::entry_t                 rd_entry;
  logic [nft_pkg::TABLE_DEPTH-1:0] valid_bits;
  logic [31:0]                     nseq;

  // create: oldest hit for the key in walk order, first free slot
  logic                         hfound;
  logic [31:0]                  hage;
  logic [nft_pkg::IDX_BITS-1:0] hidx;
  nft_pkg::entry_t              hentry;
  logic                         hmatch;
  logic                         free_found;
  logic [nft_pkg::IDX_BITS-1:0] free_idx;
  // find: oldest expired route, best live route older than it
  logic                         efound;
  logic [31:0]                  eage;
  logic [nft_pkg::IDX_BITS-1:0] eidx;
  logic                         bfound;
  logic [31:0]                  bage;
  nft_pkg::entry_t              bentry;

  logic [48:0]                  exp_sum;
  logic [nft_pkg::KEY_BITS-1:0] key_next;
  logic                         ram_we;
  logic [nft_pkg::IDX_BITS-1:0] ram_waddr;
  nft_pkg::entry_t              ram_wdata;
  logic                         slot_on;
  logic                         match;
  logic                         live;
  logic                         before_e;
  logic [31:0]                  age;
  logic                         route_on;

  assign exp_sum  = {1'b0, now_ticks} + {17'd0, ttl_ticks};
  assign key_next = dest_key[nft_pkg::KEY_BITS-1:0];
  assign route_on = (cmd_q == nft_pkg::CMD_FIND) && bfound;

  assign stat.last = (cnt == nft_pkg::IDX_BITS'(nft_pkg::TABLE_DEPTH - 1));
  assign stat.cmd  = cmd_q;

  // slot evaluation at the read stage
  always_comb begin
    slot_on  = rd_v && valid_bits[rd_idx] && (rd_entry.key == key_q);
    match    = (rd_entry.hop == hop_q) && (rd_entry.mac == mac_q);
    live     = rd_entry.expiry > now_q;
    age      = nseq - rd_entry.seq_num;
    before_e = !efound || (age > eage) || ((age == eage) && (rd_idx < eidx));
  end

  // RAM write on commit of a create
  always_comb begin
    ram_we    = ctl.commit && (cmd_q == nft_pkg::CMD_CREATE) &&
                ((hfound && hmatch) || (!hfound && free_found));
    ram_waddr = hfound ? hidx : free_idx;
    if (hfound) begin
      ram_wdata        = hentry;
      ram_wdata.expiry = (exp_q > hentry.expiry) ? exp_q : hentry.expiry;
    end else begin
      ram_wdata.key     = key_q;
      ram_wdata.hop     = hop_q;
      ram_wdata.mac     = mac_q;
      ram_wdata.expiry  = exp_q;
      ram_wdata.port    = port_q;
      ram_wdata.quality = qual_q;
      ram_wdata.seq_num = nseq;
    end
  end

  nft_ram #(
    .WIDTH($bits(nft_pkg::entry_t)),
    .DEPTH(nft_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt),
    .rdata(rd_entry)
  );

  // command capture, counter and trackers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      key_q  <= key_next;
      hop_q  <= hop_name;
      mac_q  <= hop_mac;
      exp_q  <= exp_sum[48] ? 48'hFFFF_FFFF_FFFF : exp_sum[47:0];
      port_q <= port_index;
      qual_q <= link_quality;
      now_q  <= now_ticks;
    end
    rd_idx <= cnt;

    if (ctl.load || ctl.restart) begin
      cnt <= '0;
    end else if (ctl.run) begin
      cnt <= stat.last ? '0 : cnt + 1'b1;
    end

    if (ctl.load) begin
      hfound     <= 1'b0;
      free_found <= 1'b0;
      efound     <= 1'b0;
    end else if (rd_v && !ctl.pass_b) begin
      if (!valid_bits[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (slot_on && (cmd_q == nft_pkg::CMD_CREATE) &&
          (match || (rd_entry.quality >= qual_q)) && (!hfound || age > hage)) begin
        hfound <= 1'b1;
        hage   <= age;
        hidx   <= rd_idx;
        hentry <= rd_entry;
        hmatch <= match;
      end
      if (slot_on && (cmd_q == nft_pkg::CMD_FIND) && !live &&
          (!efound || age > eage)) begin
        efound <= 1'b1;
        eage   <= age;
        eidx   <= rd_idx;
      end
    end

    if (ctl.load || ctl.restart) begin
      bfound <= 1'b0;
    end else if (rd_v && ctl.pass_b && slot_on && live && before_e) begin
      if (!bfound || (rd_entry.quality > bentry.quality) ||
          ((rd_entry.quality == bentry.quality) && (age > bage))) begin
        bfound <= 1'b1;
        bage   <= age;
        bentry <= rd_entry;
      end
    end

    // result on commit; route fields only for a found route
    if (ctl.commit) begin
      route_hop     <= route_on ? bentry.hop : '0;
      route_mac     <= route_on ? bentry.mac : '0;
      route_port    <= route_on ? bentry.port : '0;
      route_quality <= route_on ? bentry.quality : '0;
      case (cmd_q)
        nft_pkg::CMD_CREATE: begin
          if (hfound) begin
            status <= hmatch ? nft_pkg::ST_REFRESHED : nft_pkg::ST_REJECTED;
          end else begin
            status <= free_found ? nft_pkg::ST_INSERTED : nft_pkg::ST_FULL;
          end
        end
        nft_pkg::CMD_FIND: begin
          status <= bfound ? nft_pkg::ST_FOUND : nft_pkg::ST_NO_ROUTE;
        end
        nft_pkg::CMD_REMOVE: status <= nft_pkg::ST_REMOVED;
        default:             status <= nft_pkg::ST_NO_ROUTE;
      endcase
    end
  end

  // control state: valid bits, sequence counter, read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      nseq       <= '0;
      rd_v       <= 1'b0;
    end else begin
      rd_v <= ctl.run;
      if (slot_on && (cmd_q == nft_pkg::CMD_REMOVE)) begin
        valid_bits[rd_idx] <= 1'b0;
      end
      if (ctl.commit && (cmd_q == nft_pkg::CMD_CREATE) && !hfound && free_found) begin
        valid_bits[free_idx] <= 1'b1;
        nseq                 <= nseq + 1'b1;
      end
      if (ctl.commit && (cmd_q == nft_pkg::CMD_FIND) && efound) begin
        valid_bits[eidx] <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // RAM is never written while a scan is reading it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !rd_v && !ctl.run)
    else $error("route RAM written during scan");

  // sequence counter advances only on an insert
  a_seq_on_insert: assert property (@(posedge clk) disable iff (rst)
    (nseq != $past(nseq)) |-> $past(ctl.commit && cmd_q == nft_pkg::CMD_CREATE))
    else $error("sequence advanced without insert");

  // reset empties the table
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (valid_bits == '0))
    else $error("table not empty after reset");
`endif

endmodule
`default_nettype wire

### hdl/nft_ctrl.sv
// Controller: sequences scan passes, commit and the result transfer.
`default_nettype none
module nft_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output nft_pkg::ctl_t       ctl,
  input  wire nft_pkg::stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  state_t state;
  logic   pass_b;
  logic   can_post;

  assign in_ready = (state == S_IDLE);
  assign can_post = !out_valid || out_ready;

  // command decode
  always_comb begin
    ctl.load    = (state == S_IDLE) && in_valid;
    ctl.run     = (state == S_SCAN);
    ctl.restart = (state == S_DRAIN) && (stat.cmd == nft_pkg::CMD_FIND) && !pass_b;
    ctl.pass_b  = pass_b;
    ctl.commit  = (state == S_DECIDE) && can_post;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass_b    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pass_b <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (ctl.restart) begin
            pass_b <= 1'b1;
            state  <= S_SCAN;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (can_post) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a pending result is never dropped
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");

  // commit never overwrites a pending result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (!out_valid || out_ready))
    else $error("commit over pending result");

  // second pass is only for find
  a_pass_b_find: assert property (@(posedge clk) disable iff (rst)
    (ctl.run && pass_b) |-> (stat.cmd == nft_pkg::CMD_FIND))
    else $error("second pass on non-find");
`endif

endmodule
`default_nettype wire

### hdl/name_forwarding_table.sv
// Top level of the name forwarding table.
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | command, dest_key, hop_name, hop_mac, ttl_ticks,
//          |                      | port_index, link_quality, now_ticks
//  output  | out_valid / out_ready| status, route_hop, route_mac, route_port, route_quality
//
// The scan walks the route RAM read port at one slot per cycle.
// Find scans twice: first for the oldest expired route, then for the best live one.
// Reset (rst, synchronous) empties the table and the sequence counter.
// A result waiting on out_ready holds back the next commit; the next input is taken meanwhile.
`default_nettype none
module name_forwarding_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] dest_key,
  input  wire logic [31:0] hop_name,
  input  wire logic [47:0] hop_mac,
  input  wire logic [31:0] ttl_ticks,
  input  wire logic [7:0]  port_index,
  input  wire logic [15:0] link_quality,
  input  wire logic [47:0] now_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      route_hop,
  output logic [47:0]      route_mac,
  output logic [7:0]       route_port,
  output logic [15:0]      route_quality
);

  nft_pkg::ctl_t  ctl;
  nft_pkg::stat_t stat;

  nft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  nft_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .command      (command),
    .dest_key     (dest_key),
    .hop_name     (hop_name),
    .hop_mac      (hop_mac),
    .ttl_ticks    (ttl_ticks),
    .port_index   (port_index),
    .link_quality (link_quality),
    .now_ticks    (now_ticks),
    .status       (status),
    .route_hop    (route_hop),
    .route_mac    (route_mac),
    .route_port   (route_port),
    .route_quality(route_quality)
  );

endmodule
`default_nettype wire
